[design/otb_pkg.sv]
// ----------------------------------------------------------------------------
// otb_pkg
// Shared types, widths and constants of the Otsu threshold binarizer.
// ----------------------------------------------------------------------------
package otb_pkg;

  localparam int FRAME_PIXELS_LOG2 = 20;
  localparam int GRAY_LEVELS       = 256;
  localparam int GRAY_W            = $clog2(GRAY_LEVELS);
  localparam int CNT_W             = FRAME_PIXELS_LOG2 + 1;
  localparam int TN_W              = CNT_W + GRAY_W;
  localparam int TS_W              = TN_W + GRAY_W;
  localparam int PROD_W            = TS_W + TN_W;
  localparam int NUM_W             = 2 * PROD_W;
  localparam int DEN_W             = 2 * TN_W;

  localparam int SUM_W       = 15;
  localparam int W_RED       = 30;
  localparam int W_GREEN     = 59;
  localparam int W_BLUE      = 11;
  localparam int RECIP       = 41944;
  localparam int RECIP_W     = 16;
  localparam int RECIP_SHIFT = 22;

  localparam int LIMB_W      = 32;
  localparam int MUL_A_LIMBS = 5;
  localparam int MUL_B_LIMBS = 3;
  localparam int MUL_A_W     = MUL_A_LIMBS * LIMB_W;
  localparam int MUL_B_W     = MUL_B_LIMBS * LIMB_W;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [GRAY_W-1:0] PIX_BLACK = '0;
  localparam logic [GRAY_W-1:0] PIX_WHITE = '1;

  typedef enum logic {
    OP_HIST = 1'b0,
    OP_BIN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SUM_W-1:0]  sum;
    logic [GRAY_W-1:0] gray_in;
    logic              last;
  } item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_cmd_t;

endpackage

[design/otb_front.sv]
// ----------------------------------------------------------------------------
// otb_front
// Takes input transactions, forms the weighted color sum and pushes items.
// ----------------------------------------------------------------------------
module otb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_gray_in,
  input  logic                  in_last_pixel,
  input  logic                  q_full,
  output logic                  q_push,
  output otb_pkg::item_t        q_item
);
  import otb_pkg::*;

  logic        valid_r;
  op_t         op_r;
  logic [7:0]  red_r, green_r, blue_r, gin_r;
  logic        last_r;
  logic        accept;

  assign q_push = valid_r & ~q_full;
  assign busy   = valid_r & q_full;
  assign accept = start & ~busy;

  always_comb begin
    q_item.op      = op_r;
    q_item.sum     = SUM_W'(W_RED) * SUM_W'(red_r) + SUM_W'(W_GREEN) * SUM_W'(green_r)
                   + SUM_W'(W_BLUE) * SUM_W'(blue_r);
    q_item.gray_in = gin_r;
    q_item.last    = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
    if (accept) begin
      op_r    <= op_t'(in_operation);
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      gin_r   <= in_gray_in;
      last_r  <= in_last_pixel;
    end
  end

endmodule

[design/otb_queue.sv]
// ----------------------------------------------------------------------------
// otb_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module otb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  otb_pkg::item_t push_item,
  input  logic           pop,
  output otb_pkg::item_t head,
  output logic           full,
  output logic           empty
);
  import otb_pkg::*;

  item_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]     count_r;

  assign full  = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[design/otb_mul.sv]
// ----------------------------------------------------------------------------
// otb_mul
// Limb-serial wide multiplier: one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module otb_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  otb_pkg::mul_cmd_t             cmd,
  output logic                          done,
  output logic [otb_pkg::MUL_P_W-1:0]   prod
);
  import otb_pkg::*;

  localparam int IA_W = $clog2(MUL_A_LIMBS);
  localparam int IB_W = $clog2(MUL_B_LIMBS);
  localparam int POS_W = $clog2(MUL_A_LIMBS + MUL_B_LIMBS);

  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_B_W-1:0]   b_r;
  logic [IA_W-1:0]      ia_r;
  logic [IB_W-1:0]      ib_r;
  logic                 issue_r, pv_r, plast_r, done_r;
  logic [2*LIMB_W-1:0]  pp_r;
  logic [POS_W-1:0]     pos_r;
  logic [MUL_P_W-1:0]   acc_r;
  logic                 last_pair;

  assign last_pair = (ia_r == IA_W'(MUL_A_LIMBS-1)) && (ib_r == IB_W'(MUL_B_LIMBS-1));
  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= pv_r & plast_r;
      pv_r   <= issue_r;
      if (cmd.start) begin
        issue_r <= 1'b1;
      end else if (issue_r && last_pair) begin
        issue_r <= 1'b0;
      end
    end
    if (cmd.start) begin
      a_r   <= cmd.a;
      b_r   <= cmd.b;
      ia_r  <= '0;
      ib_r  <= '0;
      acc_r <= '0;
    end else begin
      if (issue_r) begin
        pp_r    <= {{LIMB_W{1'b0}}, a_r[ia_r*LIMB_W +: LIMB_W]}
                 * {{LIMB_W{1'b0}}, b_r[ib_r*LIMB_W +: LIMB_W]};
        pos_r   <= POS_W'(ia_r) + POS_W'(ib_r);
        plast_r <= last_pair;
        if (ib_r == IB_W'(MUL_B_LIMBS-1)) begin
          ib_r <= '0;
          ia_r <= ia_r + 1'b1;
        end else begin
          ib_r <= ib_r + 1'b1;
        end
      end
      if (pv_r) begin
        acc_r <= acc_r + (MUL_P_W'(pp_r) << (pos_r * LIMB_W));
      end
    end
  end

endmodule

[design/otb_back.sv]
// ----------------------------------------------------------------------------
// otb_back
// Executes items: gray conversion, histogram update, Otsu search, binarize.
// ----------------------------------------------------------------------------
module otb_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  otb_pkg::item_t       head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_strobe,
  output logic [7:0]           out_gray_out,
  output logic [7:0]           out_binary_out,
  output logic [7:0]           out_threshold_out,
  output logic                 out_threshold_valid
);
  import otb_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE, B_GRAY, B_RD, B_WR, B_TRD, B_TACC, B_PRD, B_PACC, B_CHK,
    B_MA, B_MB, B_D, B_MNUM, B_MDEN, B_MP1, B_MP2, B_NEXT, B_DONE
  } state_t;

  state_t              state_r;
  item_t               it_r;
  logic [GRAY_W-1:0]   gray_r, thr_r, idx_r, best_t_r;
  logic [CNT_W-1:0]    hist_mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] hv_r;
  logic [CNT_W-1:0]    rd_data_r;
  logic                rd_hit_r;
  logic [GRAY_W-1:0]   rd_addr;
  logic [CNT_W-1:0]    h;
  logic [TN_W-1:0]     tn_r, n1_r, n2_c;
  logic [TS_W-1:0]     ts_r, s1_r, s2_c;
  logic [PROD_W-1:0]   pa_r, pb_r, d_c;
  logic [NUM_W-1:0]    num_r, best_num_r;
  logic [DEN_W-1:0]    den_r, best_den_r;
  logic [MUL_P_W-1:0]  p1_r, mul_p;
  logic                mul_done;
  mul_cmd_t            cmd_r;
  logic [SUM_W+RECIP_W-1:0] gp_c;
  logic [TS_W-1:0]     ih_c;

  otb_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd_r),
    .done (mul_done),
    .prod (mul_p)
  );

  assign q_pop   = (state_r == B_IDLE) && !q_empty;
  assign rd_addr = (state_r == B_RD) ? gray_r : idx_r;
  assign h       = rd_hit_r ? rd_data_r : '0;
  assign n2_c    = tn_r - n1_r;
  assign s2_c    = ts_r - s1_r;
  assign d_c     = (pa_r >= pb_r) ? (pa_r - pb_r) : (pb_r - pa_r);
  assign gp_c    = (SUM_W+RECIP_W)'(it_r.sum) * (SUM_W+RECIP_W)'(RECIP);
  assign ih_c    = TS_W'(idx_r) * TS_W'(h);

  always_ff @(posedge clk) begin
    rd_data_r <= hist_mem[rd_addr];
    rd_hit_r  <= hv_r[rd_addr];
    if (state_r == B_WR) begin
      hist_mem[gray_r] <= (h == '1) ? h : h + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      thr_r      <= '0;
      hv_r       <= '0;
      out_strobe <= 1'b0;
      cmd_r.start <= 1'b0;
    end else begin
      out_strobe  <= 1'b0;
      cmd_r.start <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            it_r    <= head;
            state_r <= B_GRAY;
          end
        end
        B_GRAY: begin
          if (it_r.op == OP_BIN) begin
            out_strobe          <= 1'b1;
            out_gray_out        <= '0;
            out_binary_out      <= (it_r.gray_in < thr_r) ? PIX_BLACK : PIX_WHITE;
            out_threshold_out   <= thr_r;
            out_threshold_valid <= 1'b0;
            state_r             <= B_IDLE;
          end else begin
            gray_r  <= gp_c[RECIP_SHIFT +: GRAY_W];
            state_r <= B_RD;
          end
        end
        B_RD: state_r <= B_WR;
        B_WR: begin
          hv_r[gray_r] <= 1'b1;
          if (it_r.last) begin
            tn_r    <= '0;
            ts_r    <= '0;
            idx_r   <= '0;
            state_r <= B_TRD;
          end else begin
            out_strobe          <= 1'b1;
            out_gray_out        <= gray_r;
            out_binary_out      <= '0;
            out_threshold_out   <= thr_r;
            out_threshold_valid <= 1'b0;
            state_r             <= B_IDLE;
          end
        end
        B_TRD: state_r <= B_TACC;
        B_TACC: begin
          tn_r <= tn_r + TN_W'(h);
          ts_r <= ts_r + ih_c;
          if (idx_r == '1) begin
            n1_r       <= '0;
            s1_r       <= '0;
            best_num_r <= '0;
            best_den_r <= DEN_W'(1);
            best_t_r   <= '0;
            state_r    <= B_PRD;
          end else begin
            state_r <= B_TRD;
          end
          idx_r <= idx_r + 1'b1;
        end
        B_PRD: state_r <= B_PACC;
        B_PACC: begin
          n1_r    <= n1_r + TN_W'(h);
          s1_r    <= s1_r + ih_c;
          state_r <= B_CHK;
        end
        B_CHK: begin
          if (n1_r == '0 || n2_c == '0) begin
            state_r <= B_NEXT;
          end else begin
            cmd_r.start <= 1'b1;
            cmd_r.a     <= MUL_A_W'(s1_r);
            cmd_r.b     <= MUL_B_W'(n2_c);
            state_r     <= B_MA;
          end
        end
        B_MA: begin
          if (mul_done) begin
            pa_r        <= mul_p[PROD_W-1:0];
            cmd_r.start <= 1'b1;
            cmd_r.a     <= MUL_A_W'(s2_c);
            cmd_r.b     <= MUL_B_W'(n1_r);
            state_r     <= B_MB;
          end
        end
        B_MB: begin
          if (mul_done) begin
            pb_r    <= mul_p[PROD_W-1:0];
            state_r <= B_D;
          end
        end
        B_D: begin
          cmd_r.start <= 1'b1;
          cmd_r.a     <= MUL_A_W'(d_c);
          cmd_r.b     <= MUL_B_W'(d_c);
          state_r     <= B_MNUM;
        end
        B_MNUM: begin
          if (mul_done) begin
            num_r       <= mul_p[NUM_W-1:0];
            cmd_r.start <= 1'b1;
            cmd_r.a     <= MUL_A_W'(n1_r);
            cmd_r.b     <= MUL_B_W'(n2_c);
            state_r     <= B_MDEN;
          end
        end
        B_MDEN: begin
          if (mul_done) begin
            den_r       <= mul_p[DEN_W-1:0];
            cmd_r.start <= 1'b1;
            cmd_r.a     <= MUL_A_W'(num_r);
            cmd_r.b     <= MUL_B_W'(best_den_r);
            state_r     <= B_MP1;
          end
        end
        B_MP1: begin
          if (mul_done) begin
            p1_r        <= mul_p;
            cmd_r.start <= 1'b1;
            cmd_r.a     <= MUL_A_W'(best_num_r);
            cmd_r.b     <= MUL_B_W'(den_r);
            state_r     <= B_MP2;
          end
        end
        B_MP2: begin
          if (mul_done) begin
            if (p1_r > mul_p) begin
              best_num_r <= num_r;
              best_den_r <= den_r;
              best_t_r   <= idx_r;
            end
            state_r <= B_NEXT;
          end
        end
        B_NEXT: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= (idx_r == '1) ? B_DONE : B_PRD;
        end
        B_DONE: begin
          thr_r               <= best_t_r;
          hv_r                <= '0;
          out_strobe          <= 1'b1;
          out_gray_out        <= gray_r;
          out_binary_out      <= '0;
          out_threshold_out   <= best_t_r;
          out_threshold_valid <= 1'b1;
          state_r             <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

[design/otsu_threshold_binarizer.sv]
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// Two-pass Otsu thresholding of a pixel stream.
// ----------------------------------------------------------------------------
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. in_operation selects a histogram pass pixel (RGB, converted to
// gray and counted) or a binarize pass pixel (in_gray_in against the stored
// threshold). in_last_pixel on a histogram pixel ends the frame.
// Result channel: exactly one result per transaction, in order, held on the
// out_ ports for one cycle while out_strobe is high; the receiver cannot stall.
// A histogram pixel does one read-modify-write of the histogram memory.
// A frame's last pixel adds the Otsu search: a total scan over all levels,
// then the split scan and, for every split with both classes non-empty,
// six limb-serial multiplications on the shared 32x32 multiplier.
// A four-entry queue lets the front keep taking transactions while the back
// works; busy rises once the queue and the front register are full.
// Reset clears the histogram valid bits, the queue and the threshold (zero).
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_gray_in,
  input  logic       in_last_pixel,
  output logic       out_strobe,
  output logic [7:0] out_gray_out,
  output logic [7:0] out_binary_out,
  output logic [7:0] out_threshold_out,
  output logic       out_threshold_valid
);
  import otb_pkg::*;

  item_t push_item, head;
  logic  push, pop, full, empty;

  otb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_gray_in   (in_gray_in),
    .in_last_pixel(in_last_pixel),
    .q_full       (full),
    .q_push       (push),
    .q_item       (push_item)
  );

  otb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  otb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_empty            (empty),
    .q_pop              (pop),
    .out_strobe         (out_strobe),
    .out_gray_out       (out_gray_out),
    .out_binary_out     (out_binary_out),
    .out_threshold_out  (out_threshold_out),
    .out_threshold_valid(out_threshold_valid)
  );

endmodule
